/* hw/rtl/bsrf_pkg.sv */
// ----------------------------------------------------------------------------
// bsrf_pkg - shared definitions for the backend selector
// Request and mode codes, register indexes, field widths and count caps.
// ----------------------------------------------------------------------------
`default_nettype none

package bsrf_pkg;

	// Field widths
	localparam int unsigned REQ_TYPE_W = 2;
	localparam int unsigned HOST_W     = 4;
	localparam int unsigned COUNT_W    = 5;
	localparam int unsigned HOSTS      = 16;
	localparam int unsigned SLOTS      = 16;
	localparam int unsigned TABLE_W    = SLOTS * HOST_W;

	// Capacity of the host set and the rotation table
	localparam int unsigned MAX_HOSTS   = 16;
	localparam int unsigned TABLE_SLOTS = 16;
	localparam logic [COUNT_W-1:0] HOST_CAP =
		COUNT_W'((MAX_HOSTS < HOSTS) ? MAX_HOSTS : HOSTS);
	localparam logic [COUNT_W-1:0] SLOT_CAP =
		COUNT_W'((TABLE_SLOTS < SLOTS) ? TABLE_SLOTS : SLOTS);

	// Request codes
	localparam logic [REQ_TYPE_W-1:0] REQ_SELECT  = 2'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_FAILED  = 2'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_PASSED  = 2'd2;
	localparam logic [REQ_TYPE_W-1:0] REQ_TIMEOUT = 2'd3;

	// Balance modes
	localparam logic [1:0] MODE_RR       = 2'd0;
	localparam logic [1:0] MODE_FAILOVER = 2'd1;
	localparam logic [1:0] MODE_FAILRR   = 2'd2;

	// Register indexes
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_HOSTS  = 2'd1;
	localparam logic [1:0] REG_SLOTS  = 2'd2;
	localparam logic [1:0] REG_TABLE  = 2'd3;

endpackage

`default_nettype wire

/* hw/rtl/bsrf_if.sv */
// ----------------------------------------------------------------------------
// bsrf_if - item channels of the backend selector
// Request channel (event or select) and result channel, valid/ready each.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsrf_req_if;
	import bsrf_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [REQ_TYPE_W-1:0] req_type;
	logic [HOST_W-1:0]     reported_host;

	modport source (output valid, output req_type, output reported_host, input ready);
	modport sink   (input valid, input req_type, input reported_host, output ready);
endinterface

interface bsrf_res_if;
	import bsrf_pkg::*;
	logic              valid;
	logic              ready;
	logic [HOST_W-1:0] chosen_host;
	logic              unavailable;

	modport source (output valid, output chosen_host, output unavailable, input ready);
	modport sink   (input valid, input chosen_host, input unavailable, output ready);
endinterface

`default_nettype wire

/* hw/rtl/backend_selector_rr_failover.sv */
// ----------------------------------------------------------------------------
// backend_selector_rr_failover - upstream host selector
// Round-robin, failover and fail-robin host choice over a slot table, with
// one alive bit per host kept up to date by event items.
// ----------------------------------------------------------------------------
//  channel | dir | handshake      | payload
//  req     | in  | valid/ready    | req_type, reported_host
//  res     | out | valid/ready    | chosen_host, unavailable
//  apb     | in  | psel/penable   | paddr[4:3] register, pwdata 64 bits
//
//  Event items update the alive bits and give no result.
//  A select item is accepted, scanned by the shared slot compare unit over at
//  most N candidates (N = slot count for fail-robin, host count for failover,
//  1 for round-robin), then its result waits to enter the output register.
//  req.ready is low while a select is scanned or its result is held.
//  Reset sets every host alive, pointer to slot 0 and the registers to their
//  reset values; a result stalled on res holds in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module backend_selector_rr_failover (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	bsrf_req_if.sink                            req,
	bsrf_res_if.source                          res,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [4:0]                     paddr,
	input  wire logic [bsrf_pkg::TABLE_W-1:0]   pwdata,
	output logic      [bsrf_pkg::TABLE_W-1:0]   prdata,
	output logic                                pready
);
	import bsrf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_HOLD = 3'b100
	} state_t;

	state_t               state_q;
	logic [1:0]           mode_q;
	logic [COUNT_W-1:0]   host_count_q;
	logic [COUNT_W-1:0]   slot_count_q;
	logic [TABLE_W-1:0]   slot_table_q;
	logic [HOST_W-1:0]    ptr_q;
	logic [HOSTS-1:0]     alive_q;
	logic [HOST_W-1:0]    idx_q;
	logic [COUNT_W-1:0]   cnt_q;
	logic [HOST_W-1:0]    res_host_q;
	logic                 res_unav_q;
	logic                 out_valid_q;
	logic [HOST_W-1:0]    out_host_q;
	logic                 out_unav_q;

	logic                 cfg_wr;
	logic                 req_fire;
	logic [COUNT_W-1:0]   nh;
	logic [COUNT_W-1:0]   ns;
	logic [HOST_W-1:0]    p_norm;
	logic [COUNT_W-1:0]   limit;
	logic [HOST_W-1:0]    cand;
	logic                 hit;
	logic                 last;
	logic [COUNT_W-1:0]   idx_p1;
	logic [HOST_W-1:0]    idx_wrap;
	logic [HOST_W-1:0]    idx_step;
	logic                 out_free;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		prdata = '0;
		case (paddr[4:3])
			REG_MODE:  prdata = TABLE_W'(mode_q);
			REG_HOSTS: prdata = TABLE_W'(host_count_q);
			REG_SLOTS: prdata = TABLE_W'(slot_count_q);
			default:   prdata = slot_table_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_RR;
			host_count_q <= COUNT_W'(1);
			slot_count_q <= COUNT_W'(1);
			slot_table_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[4:3])
				REG_MODE:  mode_q       <= pwdata[1:0];
				REG_HOSTS: host_count_q <= pwdata[COUNT_W-1:0];
				REG_SLOTS: slot_count_q <= pwdata[COUNT_W-1:0];
				REG_TABLE: slot_table_q <= pwdata;
				default:   ;
			endcase
		end
	end

	// Effective counts: zero acts as one, large values saturate
	always_comb begin
		if (host_count_q == '0)
			nh = COUNT_W'(1);
		else if (host_count_q > HOST_CAP)
			nh = HOST_CAP;
		else
			nh = host_count_q;
		if (slot_count_q == '0)
			ns = COUNT_W'(1);
		else if (slot_count_q > SLOT_CAP)
			ns = SLOT_CAP;
		else
			ns = slot_count_q;
	end

	// Pointer beyond the slot count starts from slot zero
	assign p_norm = ({1'b0, ptr_q} >= ns) ? '0 : ptr_q;

	// Shared slot compare unit: one slot or host per cycle
	always_comb begin
		case (mode_q)
			MODE_FAILOVER: limit = nh;
			MODE_FAILRR:   limit = ns;
			default:       limit = COUNT_W'(1);
		endcase
		cand     = (mode_q == MODE_FAILOVER) ? idx_q : slot_table_q[{idx_q, 2'b00} +: HOST_W];
		hit      = (mode_q inside {MODE_RR, MODE_FAILOVER, MODE_FAILRR}) &&
		           ({1'b0, cand} < nh) &&
		           ((mode_q == MODE_RR) || alive_q[cand]);
		last     = (cnt_q + COUNT_W'(1)) == limit;
		idx_p1   = {1'b0, idx_q} + COUNT_W'(1);
		idx_wrap = (idx_p1 >= ns) ? '0 : idx_p1[HOST_W-1:0];
		idx_step = (mode_q == MODE_FAILOVER) ? idx_p1[HOST_W-1:0] : idx_wrap;
	end

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign out_free  = !out_valid_q || res.ready;

	// Sequencer, pointer and alive bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_q   <= '0;
			alive_q <= '1;
			idx_q   <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						case (req.req_type)
							REQ_FAILED:  alive_q[req.reported_host] <= 1'b0;
							REQ_PASSED:  alive_q[req.reported_host] <= 1'b1;
							REQ_TIMEOUT: alive_q <= '0;
							default: begin
								idx_q   <= (mode_q == MODE_FAILOVER) ? '0 : p_norm;
								cnt_q   <= '0;
								state_q <= ST_SCAN;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (hit || last) begin
						if (mode_q == MODE_RR || mode_q == MODE_FAILRR)
							ptr_q <= idx_wrap;
						state_q <= ST_HOLD;
					end else begin
						idx_q <= idx_step;
						cnt_q <= cnt_q + COUNT_W'(1);
					end
				end
				ST_HOLD: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Capture the scan result
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && (hit || last)) begin
			res_host_q <= hit ? cand : '0;
			res_unav_q <= !hit;
		end
	end

	// Output register: load from hold, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == ST_HOLD && out_free)
			out_valid_q <= 1'b1;
		else if (res.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_HOLD && out_free) begin
			out_host_q <= res_host_q;
			out_unav_q <= res_unav_q;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.chosen_host = out_host_q;
	assign res.unavailable = out_unav_q;

	// Checks
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> cnt_q < limit)
		else $error("scan ran past its limit");

	a_event_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && req.req_type != REQ_SELECT) |=> state_q == ST_IDLE)
		else $error("event item left the idle state");

	a_unav_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.unavailable) |-> res.chosen_host == '0)
		else $error("unavailable result carries a host");

	a_load_from_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_HOLD))
		else $error("output loaded outside the hold state");

endmodule

`default_nettype wire
